>>> rtl/core/binary_window_edge_detector_unit_macros.svh
// Assertion macros for the binary window edge detector.
`ifndef BINARY_WINDOW_EDGE_DETECTOR_UNIT_MACROS_SVH
`define BINARY_WINDOW_EDGE_DETECTOR_UNIT_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge, disabled while rst is high.
`define BWED_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check an implication on every clock edge, disabled while rst is high.
`define BWED_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that an implication's consequent holds at the next clock edge, disabled while rst is high.
`define BWED_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BWED_ASSERT(lbl, clk, rst, prop, msg)
`define BWED_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define BWED_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/core/bwed_pkg.sv
// Shared constants for the binary window edge detector.
`timescale 1ns / 1ps
package bwed_pkg;

   // default line store depth
   localparam int MAX_WIDTH_DEFAULT = 1024;

   // size limits
   localparam int SIZE_MIN     = 3;
   localparam int HEIGHT_LIMIT = 4096;

   // gray weights, 16-bit fixed point
   localparam logic [15:0] WEIGHT_RED   = 16'd19595;
   localparam logic [15:0] WEIGHT_GREEN = 16'd38470;
   localparam logic [15:0] WEIGHT_BLUE  = 16'd7471;

   // edge values
   localparam logic [7:0] EDGE_FLAT = 8'd255;
   localparam logic [7:0] EDGE_MARK = 8'd0;

   // register reset values
   localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [7:0]  THRESHOLD_RESET    = 8'd127;

   // register indexes
   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_THRESHOLD     = 2'd2,
      CSR_OPERATOR_MODE = 2'd3
   } csr_index_type;

   // operator modes
   typedef enum logic [1:0] {
      MODE_SINGLE_DIAG = 2'd0,
      MODE_DOUBLE_DIAG = 2'd1,
      MODE_SOBEL       = 2'd2,
      MODE_PREWITT     = 2'd3
   } operator_mode_type;

endpackage

>>> rtl/core/binary_window_edge_detector_unit.sv
// Top level of the binary window edge detector: gray, threshold, line store, 3x3 test.
//
// channel  | direction | handshake              | payload
// req      | in        | req_tvalid/req_tready  | tdata: red, green, blue
// rsp      | out       | rsp_tvalid/rsp_tready  | tdata: out_column, out_row, edge_value;
//          |           |                        | tlast: frame_last
// csr      | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// One pixel per clock while rsp_tready is high; results pass stage one and the output register.
// The line store is read at acceptance and written back as the pixel leaves stage one.
// Reset clears counters, window and pipeline valids; the line store needs no clearing.
// A stalled result freezes the whole pipeline; req_tready is high unless a result is stalled.
`timescale 1ns / 1ps
`include "binary_window_edge_detector_unit_macros.svh"
module binary_window_edge_detector_unit #(
   parameter int MAX_WIDTH = bwed_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: red [7:0], green [15:8], blue [23:16]
   input  logic [23:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: out_column [9:0], out_row [21:10], edge_value [29:22], zero [31:30]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WCMP_W = (COL_W + 1 > 11) ? COL_W + 1 : 11;
   localparam int OCW    = (COL_W > 10) ? COL_W : 10;

   // configuration registers
   logic [10:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic [7:0]  threshold_ff;
   logic [1:0]  operator_mode_ff;

   // raster counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [11:0]      row_ff, row_in;

   // stage one registers
   logic             s1_valid_ff;
   logic [23:0]      prod_r_ff, prod_g_ff, prod_b_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [11:0]      s1_row_ff;
   logic             s1_has_rsp_ff;
   logic             s1_border_ff;
   logic             s1_last_ff;

   // line store: bit 1 older row, bit 0 newer row
   logic [1:0]       line_mem [MAX_WIDTH];
   logic [1:0]       line_rd_ff;

   // window and output registers
   logic [8:0]  window_ff, window_in;
   logic        rsp_valid_ff;
   logic [9:0]  rsp_col_ff;
   logic [11:0] rsp_row_ff;
   logic [7:0]  rsp_edge_ff;
   logic        rsp_last_ff;

   logic             advance, accept, s1_fire;
   logic [WCMP_W-1:0] width_eff, col_next;
   logic [12:0]      height_eff, row_next;
   logic [23:0]      gray_sum;
   logic             cur_bit;
   logic [7:0]       edge_val;
   logic [COL_W-1:0] col_m1;
   logic [OCW-1:0]   col_out;
   logic [2:0]       sum_a, sum_b, sum_c, sum_d;

   assign csr_ready  = 1'b1;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign s1_fire    = s1_valid_ff && advance;

   // write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= bwed_pkg::FRAME_WIDTH_RESET;
         frame_height_ff  <= bwed_pkg::FRAME_HEIGHT_RESET;
         threshold_ff     <= bwed_pkg::THRESHOLD_RESET;
         operator_mode_ff <= bwed_pkg::MODE_SOBEL;
      end else if (csr_valid) begin
         unique case (bwed_pkg::csr_index_type'(csr_index))
            bwed_pkg::CSR_FRAME_WIDTH:   frame_width_ff   <= csr_data[10:0];
            bwed_pkg::CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_data;
            bwed_pkg::CSR_THRESHOLD:     threshold_ff     <= csr_data[7:0];
            bwed_pkg::CSR_OPERATOR_MODE: operator_mode_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // clamp the frame size
   always_comb begin
      if (WCMP_W'(frame_width_ff) < WCMP_W'(bwed_pkg::SIZE_MIN)) begin
         width_eff = WCMP_W'(bwed_pkg::SIZE_MIN);
      end else if (WCMP_W'(frame_width_ff) > WCMP_W'(MAX_WIDTH)) begin
         width_eff = WCMP_W'(MAX_WIDTH);
      end else begin
         width_eff = WCMP_W'(frame_width_ff);
      end
      if (frame_height_ff < 13'(bwed_pkg::SIZE_MIN)) begin
         height_eff = 13'(bwed_pkg::SIZE_MIN);
      end else if (frame_height_ff > 13'(bwed_pkg::HEIGHT_LIMIT)) begin
         height_eff = 13'(bwed_pkg::HEIGHT_LIMIT);
      end else begin
         height_eff = frame_height_ff;
      end
   end

   // advance the raster counters
   always_comb begin
      col_next = WCMP_W'(col_ff) + WCMP_W'(1);
      row_next = 13'(row_ff) + 13'd1;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_next >= width_eff) begin
            col_in = '0;
            row_in = (row_next >= height_eff) ? 12'd0 : row_next[11:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage one: weight the colors and note the position
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_r_ff     <= 24'(req_tdata[7:0])   * 24'(bwed_pkg::WEIGHT_RED);
         prod_g_ff     <= 24'(req_tdata[15:8])  * 24'(bwed_pkg::WEIGHT_GREEN);
         prod_b_ff     <= 24'(req_tdata[23:16]) * 24'(bwed_pkg::WEIGHT_BLUE);
         s1_col_ff     <= col_ff;
         s1_row_ff     <= row_ff;
         s1_has_rsp_ff <= (col_ff != '0) && (row_ff != 12'd0);
         s1_border_ff  <= (WCMP_W'(col_ff) < WCMP_W'(2)) || (row_ff < 12'd2);
         s1_last_ff    <= (WCMP_W'(col_ff) == width_eff - WCMP_W'(1))
                          && (13'(row_ff) == height_eff - 13'd1);
      end
   end

   // line store: read at acceptance, written back as the pixel leaves stage one; the same
   // column comes back no sooner than three items on, so the accesses never overlap
   always_ff @(posedge clock) begin
      if (accept) begin
         line_rd_ff <= line_mem[col_ff];
      end
      if (s1_fire) begin
         line_mem[s1_col_ff] <= {line_rd_ff[0], cur_bit};
      end
   end

   // binarize the gray value
   assign gray_sum = prod_r_ff + prod_g_ff + prod_b_ff;
   assign cur_bit  = gray_sum[23:16] < threshold_ff;

   // shift each window row left, new column in on the right
   assign window_in = {cur_bit, window_ff[8:7],
                       line_rd_ff[0], window_ff[5:4],
                       line_rd_ff[1], window_ff[2:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_fire) begin
         window_ff <= window_in;
      end
   end

   // gradient zero test on the new window; index is row * 3 + column
   always_comb begin
      sum_a = '0;
      sum_b = '0;
      sum_c = '0;
      sum_d = '0;
      edge_val = bwed_pkg::EDGE_FLAT;
      case (bwed_pkg::operator_mode_type'(operator_mode_ff))
         bwed_pkg::MODE_SINGLE_DIAG: begin
            if (window_in[4] != window_in[8]) edge_val = bwed_pkg::EDGE_MARK;
         end
         bwed_pkg::MODE_DOUBLE_DIAG: begin
            if ((window_in[4] != window_in[8]) || (window_in[5] != window_in[7])) begin
               edge_val = bwed_pkg::EDGE_MARK;
            end
         end
         bwed_pkg::MODE_SOBEL: begin
            // left, right, top and bottom weighted sums
            sum_a = 3'(window_in[0]) + {1'b0, window_in[3], 1'b0} + 3'(window_in[6]);
            sum_b = 3'(window_in[2]) + {1'b0, window_in[5], 1'b0} + 3'(window_in[8]);
            sum_c = 3'(window_in[0]) + {1'b0, window_in[1], 1'b0} + 3'(window_in[2]);
            sum_d = 3'(window_in[6]) + {1'b0, window_in[7], 1'b0} + 3'(window_in[8]);
            if (!s1_border_ff && ((sum_a != sum_b) || (sum_c != sum_d))) begin
               edge_val = bwed_pkg::EDGE_MARK;
            end
         end
         default: begin
            // Prewitt: plain sums of the outer columns and rows
            sum_a = 3'(window_in[0]) + 3'(window_in[3]) + 3'(window_in[6]);
            sum_b = 3'(window_in[2]) + 3'(window_in[5]) + 3'(window_in[8]);
            sum_c = 3'(window_in[0]) + 3'(window_in[1]) + 3'(window_in[2]);
            sum_d = 3'(window_in[6]) + 3'(window_in[7]) + 3'(window_in[8]);
            if (!s1_border_ff && ((sum_a != sum_b) || (sum_c != sum_d))) begin
               edge_val = bwed_pkg::EDGE_MARK;
            end
         end
      endcase
   end

   // result position is one behind in column and row
   assign col_m1  = s1_col_ff - COL_W'(1);
   assign col_out = OCW'(col_m1);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff && s1_has_rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_col_ff  <= col_out[9:0];
         rsp_row_ff  <= s1_row_ff - 12'd1;
         rsp_edge_ff <= edge_val;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_edge_ff, rsp_row_ff, rsp_col_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `BWED_ASSERT_IMPL(a_no_line_overlap, clock, reset, accept && s1_valid_ff, col_ff != s1_col_ff, "line store read and write hit one column")
   `BWED_ASSERT_NEXT(a_rsp_follows, clock, reset, s1_fire && s1_has_rsp_ff, rsp_valid_ff, "result item lost from stage one")
   `BWED_ASSERT_NEXT(a_no_rsp_on_border, clock, reset, s1_fire && !s1_has_rsp_ff, !rsp_valid_ff, "result item invented on first row or column")
   `BWED_ASSERT_IMPL(a_reset_empty, clock, 1'b0, $past(reset), !s1_valid_ff && !rsp_valid_ff, "pipeline not empty after reset")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the binary window edge detector unit.
`timescale 1ns / 1ps
module testbench;
   import bwed_pkg::*;

   localparam int LINE_DEPTH    = MAX_WIDTH_DEFAULT;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_TARGET = 550;

   typedef struct packed {
      logic [9:0]  column;
      logic [11:0] row;
      logic [7:0]  value;
      logic        last;
   } edge_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [23:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_FRAME_WIDTH;
   logic [12:0] csr_data = '0;

   // pixels waiting to be sent and edge results still owed by the block
   logic [23:0]  pending_pixels [$];
   edge_result_t expected_edges [$];

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned csr_writes_done = 0;
   int unsigned stall_pct = 35;
   logic        pixel_taken = 1'b0;
   bit          dark_run = 1'b0;

   // shadow of the block: registers, line stores, window and raster counters
   int unsigned       cfg_width = FRAME_WIDTH_RESET;
   int unsigned       cfg_height = FRAME_HEIGHT_RESET;
   logic [7:0]        cfg_threshold = THRESHOLD_RESET;
   operator_mode_type cfg_mode = MODE_SOBEL;
   bit                older_bits [LINE_DEPTH];
   bit                newer_bits [LINE_DEPTH];
   bit [8:0]          window_bits = '0;
   int unsigned       col_count = 0;
   int unsigned       row_count = 0;

   binary_window_edge_detector_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < SIZE_MIN) return SIZE_MIN;
      if (v > hi) return hi;
      return v;
   endfunction

   // window bit k sits at window row k/3 (0 oldest) and column k%3 (0 leftmost)
   function automatic logic [7:0] flatness_of(bit [8:0] w, int unsigned c, int unsigned r);
      int p [9];
      int gx, gy;
      foreach (p[k]) p[k] = w[k];
      if (cfg_mode == MODE_SINGLE_DIAG) return (p[4] != p[8]) ? EDGE_MARK : EDGE_FLAT;
      if (cfg_mode == MODE_DOUBLE_DIAG)
         return (p[4] != p[8] || p[5] != p[7]) ? EDGE_MARK : EDGE_FLAT;
      // a centred window touching the top or left border counts as flat
      if (c < 2 || r < 2) return EDGE_FLAT;
      if (cfg_mode == MODE_SOBEL) begin
         gx = -p[0] - 2 * p[3] - p[6] + p[2] + 2 * p[5] + p[8];
         gy = -p[0] - 2 * p[1] - p[2] + p[6] + 2 * p[7] + p[8];
      end else begin
         gx = p[0] + p[3] + p[6] - p[2] - p[5] - p[8];
         gy = p[0] + p[1] + p[2] - p[6] - p[7] - p[8];
      end
      return (gx == 0 && gy == 0) ? EDGE_FLAT : EDGE_MARK;
   endfunction

   // advance the shadow by one pixel and queue the edge result it causes
   function automatic void predict_from_pixel(logic [23:0] px);
      int unsigned w, h, c, r, gray;
      bit cur, top, mid;
      bit [2:0] newcol, rb;
      bit [8:0] nw;
      edge_result_t res;
      w = clamp_size(cfg_width, LINE_DEPTH);
      h = clamp_size(cfg_height, HEIGHT_LIMIT);
      c = col_count;
      r = row_count;
      gray = (int'(WEIGHT_RED) * px[7:0] + int'(WEIGHT_GREEN) * px[15:8]
              + int'(WEIGHT_BLUE) * px[23:16]) >> 16;
      cur = (gray < cfg_threshold);
      if (c >= LINE_DEPTH) c = LINE_DEPTH - 1;
      top = older_bits[c];
      mid = newer_bits[c];
      older_bits[c] = mid;
      newer_bits[c] = cur;
      newcol = {cur, mid, top};
      nw = '0;
      for (int k = 0; k < 3; k++) begin
         rb = window_bits[3 * k +: 3];
         nw[3 * k +: 3] = {newcol[k], rb[2:1]};
      end
      window_bits = nw;
      if (c >= 1 && r >= 1) begin
         res.column = 10'(c - 1);
         res.row    = 12'(r - 1);
         res.value  = flatness_of(window_bits, c, r);
         res.last   = (c == w - 1 && r == h - 1);
         expected_edges.push_back(res);
      end
      if (c + 1 >= w) begin
         col_count = 0;
         row_count = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_count = c + 1;
      end
   endfunction

   function automatic void apply_register(csr_index_type idx, logic [12:0] value);
      case (idx)
         CSR_FRAME_WIDTH:   cfg_width = value[10:0];
         CSR_FRAME_HEIGHT:  cfg_height = value;
         CSR_THRESHOLD:     cfg_threshold = value[7:0];
         CSR_OPERATOR_MODE: cfg_mode = operator_mode_type'(value[1:0]);
         default: ;
      endcase
   endfunction

   function automatic void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   // drive: present a new pixel once the last one was taken, idle at random, and drop rsp_tready at random
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if (!req_tvalid || pixel_taken) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= stall_pct) begin
               req_tdata  <= pending_pixels[0];
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // sample all handshakes at the rising edge, predict and check
   always @(posedge clock) begin
      edge_result_t got, want;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         cycle_count++;
         if (!reset) begin
            if (csr_valid && csr_ready) begin
               apply_register(csr_index_type'(csr_index), csr_data);
               csr_writes_done++;
            end
            pixel_taken <= req_tvalid && req_tready;
            if (req_tvalid && req_tready) begin
               predict_from_pixel(req_tdata);
               void'(pending_pixels.pop_front());
            end
            if (rsp_tvalid && rsp_tready) begin
               got.column = rsp_tdata[9:0];
               got.row    = rsp_tdata[21:10];
               got.value  = rsp_tdata[29:22];
               got.last   = rsp_tlast;
               if (expected_edges.size() == 0) begin
                  error_count++;
                  $display("%0t: expected no result, actual column %0d row %0d value %0d",
                           $time, got.column, got.row, got.value);
               end else begin
                  want = expected_edges.pop_front();
                  compare_field("out_column", want.column, got.column);
                  compare_field("out_row", want.row, got.row);
                  compare_field("edge_value", want.value, got.value);
                  compare_field("frame_last", want.last, got.last);
               end
            end
         end
      end
   end

   task automatic write_register(csr_index_type idx, int unsigned value);
      int unsigned done_before;
      done_before = csr_writes_done;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 13'(value);
      do @(negedge clock); while (csr_writes_done == done_before);
      csr_valid <= 1'b0;
   endtask

   // hold until every pixel is taken and every result is back, then drain the pipe
   task automatic wait_idle();
      while (pending_pixels.size() != 0 || expected_edges.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // runs of dark and light gray around the threshold, with some raw color noise
   task automatic queue_pixels(int unsigned count);
      logic [7:0] v;
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(99) < 30) dark_run = !dark_run;
         if ($urandom_range(99) < 15) begin
            pending_pixels.push_back(24'($urandom));
         end else begin
            if (dark_run && cfg_threshold > 0) v = $urandom_range(cfg_threshold - 1, 0);
            else v = $urandom_range(255, cfg_threshold);
            pending_pixels.push_back({v, v, v});
         end
      end
   endtask

   // send pixels until the raster counters are back at the frame start
   task automatic finish_frame();
      int unsigned w, h, n;
      w = clamp_size(cfg_width, LINE_DEPTH);
      h = clamp_size(cfg_height, HEIGHT_LIMIT);
      n = 0;
      if (col_count != 0 || row_count != 0) begin
         n = (col_count + 1 >= w) ? 1 : w - col_count;
         if (row_count + 1 < h) n += (h - row_count - 1) * w;
      end
      queue_pixels(n);
   endtask

   initial begin
      logic [23:0] corner_pixels [12];
      int unsigned random_items, phase, frames, n;
      operator_mode_type mode;
      corner_pixels = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
                        24'hFF0000, 24'h7F7F7F, 24'h808080, 24'h00FFFF,
                        24'hFFFF00, 24'hFF00FF, 24'h030201, 24'hFCFDFE};
      random_items = 0;
      phase = 0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: one small frame of saturated and mid-gray colors
      write_register(CSR_FRAME_WIDTH, 4);
      write_register(CSR_FRAME_HEIGHT, 3);
      write_register(CSR_THRESHOLD, 128);
      write_register(CSR_OPERATOR_MODE, MODE_SOBEL);
      foreach (corner_pixels[i]) pending_pixels.push_back(corner_pixels[i]);
      wait_idle();

      // random: whole frames per setting, cycling through every operator
      while (random_items < RANDOM_TARGET) begin
         mode = operator_mode_type'(phase % 4);
         case (phase)
            0: begin
               write_register(CSR_FRAME_WIDTH, 0);
               write_register(CSR_FRAME_HEIGHT, 0);
            end
            1: begin
               write_register(CSR_FRAME_WIDTH, 2);
               write_register(CSR_FRAME_HEIGHT, 1);
            end
            4: begin
               write_register(CSR_FRAME_WIDTH, 10);
               write_register(CSR_FRAME_HEIGHT, 4);
            end
            default: begin
               write_register(CSR_FRAME_WIDTH, $urandom_range(9, 3));
               write_register(CSR_FRAME_HEIGHT, $urandom_range(6, 3));
            end
         endcase
         if (phase == 2) write_register(CSR_THRESHOLD, 0);
         else if (phase == 3) write_register(CSR_THRESHOLD, 255);
         else write_register(CSR_THRESHOLD, $urandom_range(215, 40));
         write_register(CSR_OPERATOR_MODE, mode);
         // one long stretch with no idling on either side
         stall_pct = (phase == 4) ? 0 : 35;
         frames = (phase == 4) ? 4 : $urandom_range(3, 1);
         n = frames * clamp_size(cfg_width, LINE_DEPTH) * clamp_size(cfg_height, HEIGHT_LIMIT);
         queue_pixels(n);
         random_items += n;
         wait_idle();
         phase++;
      end
      stall_pct = 35;

      // widest line: two full rows and a few pixels of the last one
      write_register(CSR_FRAME_WIDTH, 2047);
      write_register(CSR_FRAME_HEIGHT, 3);
      write_register(CSR_THRESHOLD, 100);
      write_register(CSR_OPERATOR_MODE, MODE_DOUBLE_DIAG);
      queue_pixels(2 * LINE_DEPTH + 8);
      wait_idle();

      // shrink the width mid-frame and open the tallest frame
      write_register(CSR_FRAME_WIDTH, 5);
      write_register(CSR_FRAME_HEIGHT, 8191);
      write_register(CSR_OPERATOR_MODE, MODE_PREWITT);
      queue_pixels(31);
      wait_idle();

      // shrink the height below the current row so the frame wraps early
      write_register(CSR_FRAME_HEIGHT, 0);
      write_register(CSR_OPERATOR_MODE, MODE_SOBEL);
      finish_frame();
      wait_idle();

      // largest legal sizes at a frame start, then cut back mid-row
      write_register(CSR_FRAME_WIDTH, 1024);
      write_register(CSR_FRAME_HEIGHT, 4096);
      write_register(CSR_THRESHOLD, 255);
      write_register(CSR_OPERATOR_MODE, MODE_SINGLE_DIAG);
      queue_pixels(6);
      wait_idle();
      write_register(CSR_FRAME_WIDTH, 3);
      write_register(CSR_FRAME_HEIGHT, 3);
      finish_frame();
      wait_idle();

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/bwed_pkg.sv
rtl/core/binary_window_edge_detector_unit.sv
tb/testbench.sv
